>>> design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes of the sorted set table: request kinds and the
// states of the table sequencer.
// ----------------------------------------------------------------------------
package sst_pkg;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_RESOLVE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_REM_CMP,
      ST_RESP
   } state_type;

endpackage

>>> design/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table
// Set of distinct signed values kept in sorted order in a memory with one read and one write port.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request (add, remove or search) first
// scans the stored values for a match; each entry visited is read from the
// memory into a register and then compared. A successful add then moves up
// the entries that sort after the new value, and a successful remove moves
// the following entries down, again by a read and then a write of each moved
// entry. The result waits in an output register, and the next request is
// taken as soon as the sequencer is back in idle. The store needs no clearing
// after reset: only entries below the count are ever read.
// The order bit may only be written while no request is in progress.
module sorted_set_table #(
   parameter int CAPACITY    = 128,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_wdata,   // descending_order
   // requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata, // element_value
   input  logic [1:0]                           req_tuser,   // kind
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // success, element_count[7:0], is_empty, is_full, zero fill
   output logic [15:0]                          rsp_tdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   sst_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   logic                   desc_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [1:0]             kind_ff, kind_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   found_ff, found_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   logic [CW-1:0]          cnt_next;
   logic                   goes_before;
   logic                   is_full_next;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == sst_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign goes_before = desc_ff ? ($signed(val_ff) > $signed(rd_data_ff))
                                : ($signed(val_ff) < $signed(rd_data_ff));

   // count after the current request
   always_comb begin
      cnt_next = count_ff;
      if (ok_ff && kind_ff == sst_pkg::KIND_ADD) begin
         cnt_next = count_ff + CW'(1);
      end else if (ok_ff && kind_ff == sst_pkg::KIND_REMOVE) begin
         cnt_next = count_ff - CW'(1);
      end
   end

   assign is_full_next = (cnt_next == CW'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = AW'(idx_ff);
      mem_wdata    = val_ff;
      mem_raddr    = AW'(idx_ff);
      unique case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               val_in   = req_tdata[VALUE_WIDTH-1:0];
               found_in = 1'b0;
               idx_in   = '0;
               state_in = (count_ff == '0) ? sst_pkg::ST_RESOLVE : sst_pkg::ST_SCAN_RD;
            end
         end
         sst_pkg::ST_SCAN_RD: begin
            mem_raddr = AW'(idx_ff);
            state_in  = sst_pkg::ST_SCAN_CMP;
         end
         sst_pkg::ST_SCAN_CMP: begin
            if (rd_data_ff == val_ff) begin
               found_in = 1'b1;
               state_in = sst_pkg::ST_RESOLVE;
            end else if ((idx_ff + CW'(1)) == count_ff) begin
               state_in = sst_pkg::ST_RESOLVE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = sst_pkg::ST_SCAN_RD;
            end
         end
         sst_pkg::ST_RESOLVE: begin
            state_in = sst_pkg::ST_RESP;
            case (kind_ff)
               sst_pkg::KIND_ADD: begin
                  ok_in = ~found_ff && (count_ff != CW'(CAPACITY));
                  if (~found_ff && (count_ff != CW'(CAPACITY))) begin
                     idx_in   = count_ff;
                     state_in = (count_ff == '0) ? sst_pkg::ST_INS_PUT : sst_pkg::ST_INS_RD;
                  end
               end
               sst_pkg::KIND_REMOVE: begin
                  ok_in = found_ff;
                  if (found_ff && ((idx_ff + CW'(1)) != count_ff)) begin
                     state_in = sst_pkg::ST_REM_RD;
                  end
               end
               sst_pkg::KIND_SEARCH: begin
                  ok_in = found_ff;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         sst_pkg::ST_INS_RD: begin
            mem_raddr = AW'(idx_ff - CW'(1));
            state_in  = sst_pkg::ST_INS_CMP;
         end
         sst_pkg::ST_INS_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(idx_ff);
            if (goes_before) begin
               mem_wdata = rd_data_ff;
               idx_in    = idx_ff - CW'(1);
               state_in  = (idx_ff == CW'(1)) ? sst_pkg::ST_INS_PUT : sst_pkg::ST_INS_RD;
            end else begin
               mem_wdata = val_ff;
               state_in  = sst_pkg::ST_RESP;
            end
         end
         sst_pkg::ST_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(idx_ff);
            mem_wdata = val_ff;
            state_in  = sst_pkg::ST_RESP;
         end
         sst_pkg::ST_REM_RD: begin
            mem_raddr = AW'(idx_ff + CW'(1));
            state_in  = sst_pkg::ST_REM_CMP;
         end
         sst_pkg::ST_REM_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(idx_ff);
            mem_wdata = rd_data_ff;
            idx_in    = idx_ff + CW'(1);
            state_in  = ((idx_ff + CW'(2)) == count_ff) ? sst_pkg::ST_RESP : sst_pkg::ST_REM_RD;
         end
         sst_pkg::ST_RESP: begin
            if (~rsp_valid_ff || rsp_tready) begin
               count_in     = cnt_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, is_full_next, (cnt_next == '0), 8'(cnt_next), ok_ff};
               state_in     = sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   // value store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         count_ff     <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      found_ff    <= found_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("stored count above capacity");

   a_count_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> $past(state_ff == sst_pkg::ST_RESP))
      else $error("count changed outside result stage");

   a_ins_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::ST_INS_RD) |-> (idx_ff != '0 && idx_ff < CW'(CAPACITY)))
      else $error("insert move index out of range");

   a_rem_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::ST_REM_RD) |-> ((idx_ff + CW'(1)) < count_ff))
      else $error("remove move reads beyond stored values");
`endif

endmodule

>>> tb/sorted_set_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_table_test
// Self-checking testbench of the sorted set table.
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream and every response on the rsp_ stream is
// compared against a shadow copy of the table kept in the testbench. Directed
// cases cover the empty table, the value extremes, duplicates, misses and the
// unused kind. Random traffic then fills the table to capacity, flips the sort
// order with values stored, and runs under several idle and backpressure
// patterns, including a long receiver hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module sorted_set_table_test;

   localparam int CAPACITY       = 128;
   localparam int VALUE_WIDTH    = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 300;

   localparam logic [1:0]         KIND_UNUSED = 2'd3;
   localparam logic signed [31:0] MIN_VALUE   = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_VALUE   = 32'sh7fff_ffff;

   typedef struct packed {
      logic       success;
      logic [7:0] element_count;
      logic       is_empty;
      logic       is_full;
   } table_status_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // shadow table
   logic signed [31:0] shadow_values [CAPACITY];
   int                 shadow_count = 0;
   logic               shadow_descending = 1'b0;

   table_status_type status_q [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_ticket    = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   sorted_set_table #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic bit sorts_ahead(logic signed [31:0] a, logic signed [31:0] b);
      return shadow_descending ? (a > b) : (a < b);
   endfunction

   function automatic int shadow_locate(logic signed [31:0] value);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_values[i] == value) return i;
      return -1;
   endfunction

   function automatic table_status_type apply_to_shadow(logic [1:0] req_kind,
                                                        logic signed [31:0] value);
      table_status_type st;
      int               pos;
      int               i;
      bit               ok;
      ok = 1'b0;
      case (req_kind)
         sst_pkg::KIND_ADD: begin
            if (shadow_locate(value) < 0 && shadow_count < CAPACITY) begin
               i = shadow_count;
               while (i > 0 && sorts_ahead(value, shadow_values[i-1])) begin
                  shadow_values[i] = shadow_values[i-1];
                  i--;
               end
               shadow_values[i] = value;
               shadow_count++;
               ok = 1'b1;
            end
         end
         sst_pkg::KIND_REMOVE: begin
            pos = shadow_locate(value);
            if (pos >= 0) begin
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_values[i] = shadow_values[i+1];
               shadow_count--;
               ok = 1'b1;
            end
         end
         sst_pkg::KIND_SEARCH: ok = (shadow_locate(value) >= 0);
         default: ok = 1'b0;
      endcase
      st.success       = ok;
      st.element_count = shadow_count[7:0];
      st.is_empty      = (shadow_count == 0);
      st.is_full       = (shadow_count >= CAPACITY);
      return st;
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 50 && shadow_count > 0)
         return shadow_values[$urandom_range(shadow_count - 1)];
      if (r < 85)
         return int'($urandom_range(160)) - 80;
      if (r < 95)
         return $urandom;
      case ($urandom_range(3))
         0: return MIN_VALUE;
         1: return MAX_VALUE;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic [1:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) return sst_pkg::KIND_ADD;
      if (r < 75) return sst_pkg::KIND_REMOVE;
      if (r < 95) return sst_pkg::KIND_SEARCH;
      return KIND_UNUSED;
   endfunction

   task automatic send_request(input logic [1:0] req_kind, input logic signed [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= req_kind;
      do @(posedge clock); while (!req_tready);
      status_q.push_back(apply_to_shadow(req_kind, value));
   endtask

   task automatic send_random(input int n);
      repeat (n) send_request(pick_kind(), pick_value());
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_order(input logic descending);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= descending;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_descending = descending;
   endtask

   task automatic remove_all();
      while (shadow_count > 0) send_request(sst_pkg::KIND_REMOVE, shadow_values[0]);
   endtask

   task automatic test_directed_cases();
      write_order(1'b0);
      send_request(sst_pkg::KIND_SEARCH, 32'sd0);
      send_request(sst_pkg::KIND_REMOVE, 32'sd5);
      send_request(KIND_UNUSED, 32'sd7);
      send_request(sst_pkg::KIND_ADD, 32'sd0);
      send_request(sst_pkg::KIND_ADD, MIN_VALUE);
      send_request(sst_pkg::KIND_ADD, MAX_VALUE);
      send_request(sst_pkg::KIND_ADD, -32'sd1);
      send_request(sst_pkg::KIND_ADD, 32'sd1);
      send_request(sst_pkg::KIND_ADD, 32'sd0);
      send_request(sst_pkg::KIND_SEARCH, MIN_VALUE);
      send_request(sst_pkg::KIND_SEARCH, MAX_VALUE);
      send_request(sst_pkg::KIND_SEARCH, 32'sd2);
      send_request(sst_pkg::KIND_REMOVE, -32'sd1);
      send_request(sst_pkg::KIND_REMOVE, -32'sd1);
      send_request(KIND_UNUSED, MAX_VALUE);
      send_request(sst_pkg::KIND_ADD, 32'sh5555_5555);
      send_request(sst_pkg::KIND_ADD, 32'shaaaa_aaaa);
      send_request(sst_pkg::KIND_REMOVE, MIN_VALUE);
      send_request(sst_pkg::KIND_REMOVE, MAX_VALUE);
      send_request(sst_pkg::KIND_SEARCH, 32'sd0);
   endtask

   task automatic test_fill_to_capacity();
      while (shadow_count < CAPACITY) send_request(sst_pkg::KIND_ADD, $urandom);
      send_request(sst_pkg::KIND_ADD, $urandom);
      send_request(sst_pkg::KIND_ADD, shadow_values[5]);
      send_request(sst_pkg::KIND_SEARCH, shadow_values[CAPACITY - 1]);
      send_request(KIND_UNUSED, $urandom);
      send_request(sst_pkg::KIND_SEARCH, $urandom);
      send_request(sst_pkg::KIND_REMOVE, shadow_values[$urandom_range(CAPACITY - 1)]);
      send_request(sst_pkg::KIND_ADD, $urandom);
      send_request(sst_pkg::KIND_ADD, $urandom);
      send_random(30);
      repeat (70)
         if (shadow_count > 0)
            send_request(sst_pkg::KIND_REMOVE,
                         shadow_values[$urandom_range(shadow_count - 1)]);
   endtask

   // stored values keep their old order after the flip
   task automatic test_order_flip_with_values();
      write_order(1'b1);
      send_random(100);
      remove_all();
      write_order(1'b0);
   endtask

   task automatic test_descending_order();
      write_order(1'b1);
      send_random(200);
      write_order(1'b0);
   endtask

   task automatic test_idle_phases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(180);
      send_idle_pct  = 73;
      send_random(180);
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 73;
      send_random(180);
      send_idle_pct  = 26;
      recv_stall_pct = 26;
      send_random(180);
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_ticket <= hold_ticket + 1;
      send_random(40);
   endtask

   // receiver side
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen  <= hold_ticket;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      table_status_type want;
      table_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.success       = rsp_tdata[0];
         got.element_count = rsp_tdata[8:1];
         got.is_empty      = rsp_tdata[9];
         got.is_full       = rsp_tdata[10];
         if (status_q.size() == 0) begin
            $error("unexpected result transaction, data %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = status_q.pop_front();
            if (got.success !== want.success) begin
               $error("success: expected %0d, got %0d", want.success, got.success);
               mismatch_count++;
            end
            if (got.element_count !== want.element_count) begin
               $error("element_count: expected %0d, got %0d",
                      want.element_count, got.element_count);
               mismatch_count++;
            end
            if (got.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
               mismatch_count++;
            end
            if (got.is_full !== want.is_full) begin
               $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_fill_to_capacity();
      test_order_flip_with_values();
      test_descending_order();
      test_idle_phases();
      test_backpressure();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && status_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
